/* sv/ovle_pkg.sv */
// Package for the ordered value list engine.
// Holds the action, status, cell op and FSM codes and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps

package ovle_pkg;

  localparam int VAL_W   = 32;
  localparam int ACT_W   = 3;
  localparam int STS_W   = 2;
  localparam int TOTAL_W = 6;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_COUNT  = 3'd1,
    ACT_SEARCH = 3'd2,
    ACT_UPDATE = 3'd3,
    ACT_DELETE = 3'd4,
    ACT_SHOW   = 3'd5
  } act_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 2'd0,
    STS_EMPTY    = 2'd1,
    STS_NOTFOUND = 2'd2,
    STS_FULL     = 2'd3
  } sts_t;

  typedef enum logic [2:0] {
    C_HOLD,
    C_LOAD,
    C_UPDATE,
    C_SHIFT,
    C_ROTATE
  } cell_op_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_RUN,
    FSM_SHOW
  } fsm_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] key;
    logic signed [31:0] repl;
    logic signed [31:0] head;
  } cell_ctl_t;

endpackage

/* sv/ovle_cell.sv */
// One storage cell of the list chain: holds one entry, compares it with the key,
// and loads from the broadcast bus or its right neighbor. Depends on ovle_pkg.
`timescale 1ns / 1ps

module ovle_cell import ovle_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 6
) (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic [CW-1:0]       count,
  input  logic signed [31:0]  right_val,
  input  logic                seen_in,
  output logic                seen_out,
  output logic signed [31:0]  value
);

  logic signed [31:0] value_r, value_nxt;
  logic valid, is_free, is_tail, match;

  assign valid    = CW'(IDX) < count;
  assign is_free  = count == CW'(IDX);
  assign is_tail  = count == CW'(IDX + 1);
  assign match    = valid && (value_r == ctl.key);
  assign seen_out = seen_in | match;
  assign value    = value_r;

  always_comb begin
    value_nxt = value_r;
    unique case (ctl.op)
      C_HOLD: ;
      C_LOAD: if (is_free) value_nxt = ctl.key;
      C_UPDATE: if (match && !seen_in) value_nxt = ctl.repl;
      C_SHIFT: if (seen_out) value_nxt = right_val;
      C_ROTATE: value_nxt = is_tail ? ctl.head : right_val;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

/* sv/ordered_value_list_engine.sv */
// Ordered value list engine: list of signed 32-bit entries held in a chain of cells.
// Channels: input words carry action in in_tuser and key/replacement in in_tdata;
// result words carry status in out_tuser, entry total and entry value in out_tdata.
// Insert appends at the tail, search/update/delete act on the first match (all
// cells compare in parallel, first match found along the chain), show streams
// every entry in order with tlast on the final one.
// Timing: a result word is registered in the RUN state once the output register is
// free; the first show word passes through the RUN and then the SHOW state.
// Flow: one input word is taken at a time, the next only after its last result word
// is loaded; show sends one word per entry, the chain rotating one place per word sent.
// The output register holds a finished word while the next input is taken, so a
// stalled receiver only holds up the following operation, never loses a word.
// Reset (rst_n low, synchronous) empties the list and drops any pending word;
// entry cells need no clearing since only cells below the count are ever read.
// Depends on ovle_pkg and ovle_cell.
`timescale 1ns / 1ps

module ordered_value_list_engine import ovle_pkg::*; #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] key_value, [63:32] replacement
  input  logic [2:0]  in_tuser,   // [2:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [5:0] entry_total, [37:6] entry_out, [39:38] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // last
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  fsm_t               state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  act_t               act_r, act_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic signed [31:0] repl_r, repl_nxt;
  logic               ov_r, ov_nxt;
  sts_t               o_status_r, o_status_nxt;
  logic [TOTAL_W-1:0] o_total_r, o_total_nxt;
  logic signed [31:0] o_entry_r, o_entry_nxt;
  logic               o_last_r, o_last_nxt;

  cell_ctl_t          ctl;
  logic signed [31:0] cell_val [MAX_ENTRIES];
  logic signed [31:0] right_arr [MAX_ENTRIES];
  logic               seen [MAX_ENTRIES+1];
  logic               out_load, empty, found, full;
  logic [CW-1:0]      tail_idx;

  assign seen[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      if (gi == MAX_ENTRIES - 1) begin : g_end
        assign right_arr[gi] = 32'sd0;
      end else begin : g_mid
        assign right_arr[gi] = cell_val[gi+1];
      end
      ovle_cell #(.IDX(gi), .CW(CW)) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .count     (count_r),
        .right_val (right_arr[gi]),
        .seen_in   (seen[gi]),
        .seen_out  (seen[gi+1]),
        .value     (cell_val[gi])
      );
    end
  endgenerate

  assign out_load = !ov_r || out_tready;
  assign empty    = count_r == '0;
  assign full     = count_r == CW'(MAX_ENTRIES);
  assign found    = seen[MAX_ENTRIES];
  assign tail_idx = CW'(count_r - 1'b1);

  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, o_entry_r, o_total_r};
  assign out_tuser  = o_status_r;
  assign out_tlast  = o_last_r;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    act_nxt      = act_r;
    key_nxt      = key_r;
    repl_nxt     = repl_r;
    ov_nxt       = ov_r && !out_tready;
    o_status_nxt = o_status_r;
    o_total_nxt  = o_total_r;
    o_entry_nxt  = o_entry_r;
    o_last_nxt   = o_last_r;
    ctl.op       = C_HOLD;
    ctl.key      = key_r;
    ctl.repl     = repl_r;
    ctl.head     = cell_val[0];
    in_tready    = state_r == FSM_IDLE;
    unique case (state_r)
      FSM_IDLE: begin
        if (in_tvalid) begin
          act_nxt   = act_t'(in_tuser);
          key_nxt   = in_tdata[31:0];
          repl_nxt  = in_tdata[63:32];
          state_nxt = FSM_RUN;
        end
      end
      FSM_RUN: begin
        if (out_load) begin
          state_nxt    = FSM_IDLE;
          ov_nxt       = 1'b1;
          o_status_nxt = STS_OK;
          o_entry_nxt  = 32'sd0;
          o_last_nxt   = 1'b1;
          unique case (act_r)
            ACT_INSERT: begin
              if (full) begin
                o_status_nxt = STS_FULL;
              end else begin
                ctl.op    = C_LOAD;
                count_nxt = CW'(count_r + 1'b1);
              end
            end
            ACT_COUNT: begin
              if (empty) o_status_nxt = STS_EMPTY;
            end
            ACT_SEARCH, ACT_UPDATE, ACT_DELETE: begin
              if (empty) begin
                o_status_nxt = STS_EMPTY;
              end else if (!found) begin
                o_status_nxt = STS_NOTFOUND;
              end else if (act_r == ACT_UPDATE) begin
                ctl.op = C_UPDATE;
              end else if (act_r == ACT_DELETE) begin
                ctl.op    = C_SHIFT;
                count_nxt = tail_idx;
              end
            end
            ACT_SHOW: begin
              if (empty) begin
                o_status_nxt = STS_EMPTY;
              end else begin
                ov_nxt    = ov_r && !out_tready;
                state_nxt = FSM_SHOW;
                idx_nxt   = '0;
              end
            end
            default: ;
          endcase
          o_total_nxt = TOTAL_W'(count_nxt);
        end
      end
      FSM_SHOW: begin
        if (out_load) begin
          ov_nxt       = 1'b1;
          o_status_nxt = STS_OK;
          o_total_nxt  = TOTAL_W'(count_r);
          o_entry_nxt  = cell_val[0];
          o_last_nxt   = idx_r == tail_idx;
          ctl.op       = C_ROTATE;
          idx_nxt      = CW'(idx_r + 1'b1);
          if (idx_r == tail_idx) state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    act_r      <= act_nxt;
    key_r      <= key_nxt;
    repl_r     <= repl_nxt;
    o_status_r <= o_status_nxt;
    o_total_r  <= o_total_nxt;
    o_entry_r  <= o_entry_nxt;
    o_last_r   <= o_last_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == CW'($past(count_r) + 1'b1) || count_r == CW'($past(count_r) - 1'b1)))
    else $error("entry count moved by more than one");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_status_r == STS_FULL) |-> full)
    else $error("full status while list not full");

  a_mid_show: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !o_last_r) |-> (state_r == FSM_SHOW))
    else $error("non-final word outside show");
`endif

endmodule
